// ===== src/ffa_pkg.sv =====
// Shared types and constants of the first-fit chunk heap allocator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package ffa_pkg;

	localparam int CHUNK_BYTES = 32;
	localparam int FIRST_DATA_BYTES = 16;
	localparam int JUMP_BYTES = 1024;
	localparam int HEAP_CHUNKS = 4096;
	localparam int HDR_BYTES = CHUNK_BYTES - FIRST_DATA_BYTES;
	localparam int GUARD_CHUNKS = JUMP_BYTES / CHUNK_BYTES;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int JUMP_SHIFT = $clog2(JUMP_BYTES);
	localparam int ADDR_W = $clog2(HEAP_CHUNKS);
	localparam int LEN_W = 13;
	localparam int SIZE_W = 18;
	localparam int OFF_W = 17;
	localparam int TASK_W = 8;
	localparam int NEED_W = 14;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 13'd4096;

	typedef enum logic [1:0] {
		CMD_ALLOC     = 2'd0,
		CMD_FREE      = 2'd1,
		CMD_FREE_TASK = 2'd2,
		CMD_RELEASE   = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_OOM        = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_OUTSIDE    = 3'd3,
		ST_MISALIGNED = 3'd4,
		ST_ALREADY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_CUR,
		RD_J,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_MERGE,
		WR_CLEAR,
		WR_FREE,
		WR_SPLIT,
		WR_TAKE,
		WR_GROW
	} wr_sel_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [SIZE_W-1:0] used;
		logic [TASK_W-1:0] owner;
	} hdr_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    cur_clr;
		rd_sel_t rd;
		logic    adv;
		logic    acc_start;
		logic    acc_add;
		wr_sel_t wr;
		logic    end_to_last;
		logic    set_status;
		status_t status;
		logic    publish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_code_t cmd;
		logic      started;
		logic      cur_lt_end;
		logic      j_lt_end;
		logic      d_free;
		logic      fit;
		logic      split;
		logic      grow_ok;
		logic      owner_match;
		logic      off_outside;
		logic      misal;
		logic      cur_lt_idx;
		logic      cur_eq_idx;
		logic      last_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/ffa_req_if.sv =====
// Request channel: valid/ready plus one allocator request.
// No dependencies.
`default_nettype none
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [17:0] request_size;
	logic [16:0] data_offset;
	logic [7:0]  task_id;
	modport source (output valid, command, request_size, data_offset, task_id, input ready);
	modport sink (input valid, command, request_size, data_offset, task_id, output ready);
endinterface
`default_nettype wire

// ===== src/ffa_rsp_if.sv =====
// Response channel: valid/ready plus one allocator result.
// No dependencies.
`default_nettype none
interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [16:0] granted_offset;
	logic [12:0] granted_chunks;
	modport source (output valid, status, granted_offset, granted_chunks, input ready);
	modport sink (input valid, status, granted_offset, granted_chunks, output ready);
endinterface
`default_nettype wire

// ===== src/ffa_cfg_if.sv =====
// Configuration write channel for the heap limit register.
// No dependencies.
`default_nettype none
interface ffa_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/ffa_dp.sv =====
// Allocator datapath: header memory, walk pointers, heap end and result registers.
// Depends on ffa_pkg.
`default_nettype none
module ffa_dp (
	input  wire                      clk,
	input  wire                      arst_n,
	input  ffa_pkg::dp_cmd_t         cmd,
	output ffa_pkg::dp_stat_t        stat,
	input  wire [1:0]                command,
	input  wire [17:0]               request_size,
	input  wire [16:0]               data_offset,
	input  wire [7:0]                task_id,
	input  wire                      cfg_we,
	input  wire [12:0]               cfg_data,
	output logic [2:0]               status,
	output logic [16:0]              granted_offset,
	output logic [12:0]              granted_chunks
);
	import ffa_pkg::*;

	hdr_t mem [HEAP_CHUNKS];

	cmd_code_t         cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [TASK_W-1:0] task_q;
	logic [NEED_W-1:0] need_q;
	logic [NEED_W-1:0] grow_q;
	logic              below_q;
	logic              misal_q;
	logic [ADDR_W-1:0] idx_q;
	logic [LEN_W-1:0]  end_q;
	logic              started_q;
	logic [LEN_W-1:0]  limit_q;
	logic [LEN_W-1:0]  cur_q;
	logic [LEN_W-1:0]  acc_q;
	logic [TASK_W-1:0] owner_i_q;
	logic [LEN_W-1:0]  last_q;
	logic              last_free_q;
	logic [ADDR_W-1:0] rd_addr_q;
	hdr_t              d_q;
	status_t           status_q;
	logic [OFF_W-1:0]  goff_q;
	logic [LEN_W-1:0]  gch_q;
	status_t           out_status_q;
	logic [OFF_W-1:0]  out_goff_q;
	logic [LEN_W-1:0]  out_gch_q;

	logic [SIZE_W:0]   need_sum;
	logic [SIZE_W-1:0] bytes;
	logic [SIZE_W:0]   jump_sum;
	logic [OFF_W-1:0]  c_off;
	logic [LEN_W-1:0]  room;
	logic [LEN_W-1:0]  rl;
	logic [LEN_W-1:0]  j;
	logic [NEED_W:0]   new_end;
	logic [NEED_W+1:0] new_top;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	hdr_t              wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [LEN_W-1:0]  split_addr;

	// request decode
	assign need_sum = {1'b0, request_size} + (SIZE_W+1)'(HDR_BYTES - 1);
	assign bytes = (request_size == '0) ? SIZE_W'(1) : request_size;
	assign jump_sum = {1'b0, bytes} + (SIZE_W+1)'(JUMP_BYTES - 1);
	assign c_off = data_offset - OFF_W'(HDR_BYTES);

	// run length of the header in d_q, clamped at the heap end
	assign room = end_q - {1'b0, rd_addr_q};
	assign rl = (d_q.len == '0 || d_q.len > room) ? room : d_q.len;
	assign j = cur_q + acc_q;
	assign new_end = {2'b00, end_q} + {1'b0, grow_q};
	assign new_top = {1'b0, new_end} + (NEED_W+2)'(GUARD_CHUNKS);
	assign split_addr = cur_q + need_q[LEN_W-1:0];

	assign stat.cmd = cmd_q;
	assign stat.started = started_q;
	assign stat.cur_lt_end = cur_q < end_q;
	assign stat.j_lt_end = j < end_q;
	assign stat.d_free = d_q.used == '0;
	assign stat.fit = (d_q.used == '0) && ({1'b0, rl} >= need_q);
	assign stat.split = {1'b0, rl} > need_q;
	assign stat.grow_ok = (new_top <= {3'b000, limit_q}) && (new_end < (NEED_W+1)'(HEAP_CHUNKS));
	assign stat.owner_match = d_q.owner == task_q;
	assign stat.off_outside = below_q || ({1'b0, idx_q} >= end_q);
	assign stat.misal = misal_q;
	assign stat.cur_lt_idx = cur_q < {1'b0, idx_q};
	assign stat.cur_eq_idx = cur_q == {1'b0, idx_q};
	assign stat.last_free = last_free_q;

	always_comb begin
		wr_en = 1'b1;
		wr_addr = cur_q[ADDR_W-1:0];
		wr_data = '{len: d_q.len, used: '0, owner: d_q.owner};
		case (cmd.wr)
			WR_MERGE: wr_data = '{len: acc_q, used: '0, owner: owner_i_q};
			WR_CLEAR: wr_data = '{len: d_q.len, used: '0, owner: d_q.owner};
			WR_FREE: begin
				wr_addr = idx_q;
				wr_data = '{len: d_q.len, used: '0, owner: task_q};
			end
			WR_SPLIT: begin
				wr_addr = split_addr[ADDR_W-1:0];
				wr_data = '{len: rl - need_q[LEN_W-1:0], used: '0, owner: task_q};
			end
			WR_TAKE: wr_data = '{len: need_q[LEN_W-1:0], used: size_q, owner: task_q};
			WR_GROW: begin
				wr_addr = end_q[ADDR_W-1:0];
				wr_data = '{len: grow_q[LEN_W-1:0], used: '0, owner: task_q};
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.rd)
			RD_J: rd_addr = j[ADDR_W-1:0];
			RD_IDX: rd_addr = idx_q;
			default: rd_addr = cur_q[ADDR_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd != RD_NONE) begin
			d_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= '0;
			started_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.wr == WR_GROW) begin
				end_q <= new_end[LEN_W-1:0];
				started_q <= 1'b1;
			end else if (cmd.end_to_last) begin
				end_q <= last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_code_t'(command);
			size_q <= request_size;
			task_q <= task_id;
			need_q <= (request_size > SIZE_W'(FIRST_DATA_BYTES))
				? NEED_W'((need_sum >> CHUNK_SHIFT) + 1'b1) : NEED_W'(1);
			grow_q <= NEED_W'((jump_sum >> JUMP_SHIFT) << (JUMP_SHIFT - CHUNK_SHIFT));
			below_q <= data_offset < OFF_W'(HDR_BYTES);
			misal_q <= c_off[CHUNK_SHIFT-1:0] != '0;
			idx_q <= c_off[CHUNK_SHIFT +: ADDR_W];
			status_q <= ST_DONE;
			goff_q <= '0;
			gch_q <= '0;
		end
		if (cmd.cur_clr) begin
			cur_q <= '0;
			last_q <= '0;
			last_free_q <= 1'b0;
		end else if (cmd.wr == WR_MERGE) begin
			cur_q <= j;
		end else if (cmd.adv) begin
			cur_q <= cur_q + rl;
			last_q <= cur_q;
			last_free_q <= d_q.used == '0;
		end
		if (cmd.acc_start) begin
			acc_q <= rl;
			owner_i_q <= d_q.owner;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + rl;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.wr == WR_TAKE) begin
			goff_q <= {cur_q[ADDR_W-1:0], {CHUNK_SHIFT{1'b0}}} + OFF_W'(HDR_BYTES);
			gch_q <= need_q[LEN_W-1:0];
		end
		if (cmd.publish) begin
			out_status_q <= status_q;
			out_goff_q <= goff_q;
			out_gch_q <= gch_q;
		end
	end

	assign status = out_status_q;
	assign granted_offset = out_goff_q;
	assign granted_chunks = out_gch_q;

endmodule
`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// Allocator controller: sequences header walks, merges, growth and handshakes.
// Depends on ffa_pkg.
`default_nettype none
module ffa_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	input  ffa_pkg::dp_stat_t        stat,
	output ffa_pkg::dp_cmd_t         cmd
);
	import ffa_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE     = 18'b000000000000000001,
		S_DISPATCH = 18'b000000000000000010,
		S_SRCH     = 18'b000000000000000100,
		S_SRCH_D   = 18'b000000000000001000,
		S_TAKE     = 18'b000000000000010000,
		S_FWALK    = 18'b000000000000100000,
		S_FWALK_D  = 18'b000000000001000000,
		S_FCHK     = 18'b000000000010000000,
		S_TWALK    = 18'b000000000100000000,
		S_TWALK_D  = 18'b000000001000000000,
		S_MCHK     = 18'b000000010000000000,
		S_MCHK_D   = 18'b000000100000000000,
		S_MJ       = 18'b000001000000000000,
		S_MJ_D     = 18'b000010000000000000,
		S_LWALK    = 18'b000100000000000000,
		S_LWALK_D  = 18'b001000000000000000,
		S_DONE     = 18'b010000000000000000,
		S_SPARE    = 18'b100000000000000000
	} state_t;

	// where a merge pass continues
	typedef enum logic [1:0] {
		RET_DONE,
		RET_OOM,
		RET_ALLOC,
		RET_REL
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	logic   out_valid_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ret_d = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.cur_clr = 1'b1;
				if (stat.cmd == CMD_ALLOC) begin
					if (stat.started) begin
						state_d = S_SRCH;
					end else if (stat.grow_ok) begin
						cmd.wr = WR_GROW;
						state_d = S_SRCH;
					end else begin
						cmd.set_status = 1'b1;
						cmd.status = ST_OOM;
						state_d = S_DONE;
					end
				end else if (!stat.started) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_EMPTY;
					state_d = S_DONE;
				end else begin
					case (stat.cmd)
						CMD_FREE: begin
							if (stat.off_outside) begin
								cmd.set_status = 1'b1;
								cmd.status = ST_OUTSIDE;
								state_d = S_DONE;
							end else if (stat.misal) begin
								cmd.set_status = 1'b1;
								cmd.status = ST_MISALIGNED;
								state_d = S_DONE;
							end else begin
								state_d = S_FWALK;
							end
						end
						CMD_FREE_TASK: state_d = S_TWALK;
						default: begin
							ret_d = RET_REL;
							state_d = S_MCHK;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (stat.cur_lt_end) begin
					cmd.rd = RD_CUR;
					state_d = S_SRCH_D;
				end else begin
					cmd.cur_clr = 1'b1;
					state_d = S_MCHK;
					if (stat.grow_ok) begin
						cmd.wr = WR_GROW;
						ret_d = RET_ALLOC;
					end else begin
						ret_d = RET_OOM;
					end
				end
			end
			S_SRCH_D: begin
				if (stat.fit) begin
					if (stat.split) begin
						cmd.wr = WR_SPLIT;
						state_d = S_TAKE;
					end else begin
						cmd.wr = WR_TAKE;
						state_d = S_DONE;
					end
				end else begin
					cmd.adv = 1'b1;
					state_d = S_SRCH;
				end
			end
			S_TAKE: begin
				cmd.wr = WR_TAKE;
				state_d = S_DONE;
			end
			S_FWALK: begin
				if (stat.cur_lt_idx) begin
					cmd.rd = RD_CUR;
					state_d = S_FWALK_D;
				end else if (!stat.cur_eq_idx) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_MISALIGNED;
					state_d = S_DONE;
				end else begin
					cmd.rd = RD_IDX;
					state_d = S_FCHK;
				end
			end
			S_FWALK_D: begin
				cmd.adv = 1'b1;
				state_d = S_FWALK;
			end
			S_FCHK: begin
				if (stat.d_free) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_ALREADY;
					state_d = S_DONE;
				end else begin
					cmd.wr = WR_FREE;
					cmd.cur_clr = 1'b1;
					ret_d = RET_DONE;
					state_d = S_MCHK;
				end
			end
			S_TWALK: begin
				if (stat.cur_lt_end) begin
					cmd.rd = RD_CUR;
					state_d = S_TWALK_D;
				end else begin
					cmd.cur_clr = 1'b1;
					ret_d = RET_DONE;
					state_d = S_MCHK;
				end
			end
			S_TWALK_D: begin
				cmd.adv = 1'b1;
				if (!stat.d_free && stat.owner_match) begin
					cmd.wr = WR_CLEAR;
				end
				state_d = S_TWALK;
			end
			S_MCHK: begin
				if (stat.cur_lt_end) begin
					cmd.rd = RD_CUR;
					state_d = S_MCHK_D;
				end else begin
					case (ret_q)
						RET_OOM: begin
							cmd.set_status = 1'b1;
							cmd.status = ST_OOM;
							state_d = S_DONE;
						end
						RET_ALLOC: begin
							cmd.cur_clr = 1'b1;
							state_d = S_SRCH;
						end
						RET_REL: begin
							cmd.cur_clr = 1'b1;
							state_d = S_LWALK;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MCHK_D: begin
				if (stat.d_free) begin
					cmd.acc_start = 1'b1;
					state_d = S_MJ;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_MCHK;
				end
			end
			S_MJ: begin
				if (stat.j_lt_end) begin
					cmd.rd = RD_J;
					state_d = S_MJ_D;
				end else begin
					cmd.wr = WR_MERGE;
					state_d = S_MCHK;
				end
			end
			S_MJ_D: begin
				if (stat.d_free) begin
					cmd.acc_add = 1'b1;
					state_d = S_MJ;
				end else begin
					cmd.wr = WR_MERGE;
					state_d = S_MCHK;
				end
			end
			S_LWALK: begin
				if (stat.cur_lt_end) begin
					cmd.rd = RD_CUR;
					state_d = S_LWALK_D;
				end else begin
					cmd.end_to_last = stat.last_free;
					state_d = S_DONE;
				end
			end
			S_LWALK_D: begin
				cmd.adv = 1'b1;
				state_d = S_LWALK;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= RET_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/first_fit_chunk_heap_allocator.sv =====
// Top level of the first-fit chunk heap allocator: controller plus datapath.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_cfg_if, ffa_ctrl and ffa_dp.
//
// One request is worked at a time. Each run header visited is read through the single
// read port of the header memory, whose read data is registered. A search visits runs
// up to the first fit or the heap end, a free walks the runs before the freed one, and
// each merge pass visits runs up to the heap end once; a failed fit adds growth if the
// limit allows, a merge pass and, after growth, a new search. The next request is taken
// while the previous result waits on the response channel. The limit register takes a
// write on any cycle; it should only change while no request is in flight.
`default_nettype none
module first_fit_chunk_heap_allocator (
	input  wire       clk,
	input  wire       arst_n,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp,
	ffa_cfg_if.sink   cfg
);
	import ffa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (req.command),
		.request_size  (req.request_size),
		.data_offset   (req.data_offset),
		.task_id       (req.task_id),
		.cfg_we        (cfg.valid),
		.cfg_data      (cfg.data),
		.status        (rsp.status),
		.granted_offset(rsp.granted_offset),
		.granted_chunks(rsp.granted_chunks)
	);

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_DONE) |-> rsp.granted_chunks == '0)
		else $error("grant reported on a failed request");

	a_grant_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.granted_chunks != '0)
		|-> rsp.granted_offset[CHUNK_SHIFT-1:0] == CHUNK_SHIFT'(HDR_BYTES))
		else $error("granted offset not at a data area start");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in work");

endmodule
`default_nettype wire
